### rtl/wcpe_pkg.sv
package wcpe_pkg;

	// Sample and magnitude widths
	localparam int SAMPLE_BITS = 16;
	localparam int MAG_W       = SAMPLE_BITS;      // holds 2^(SAMPLE_BITS-1)
	localparam int PEAK_W      = SAMPLE_BITS - 1;  // saturated magnitude

	// Register widths
	localparam int SQUELCH_W   = 15;
	localparam int GAIN_W      = 16;
	localparam int GAIN_FRAC   = 8;                // Q8.8
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	// Width for the squelch compare
	localparam int CMP_W       = ((MAG_W > SQUELCH_W) ? MAG_W : SQUELCH_W) + 1;
	localparam int PROD_W      = MAG_W + GAIN_W;

	localparam logic [GAIN_W-1:0]    GAIN_UNITY   = GAIN_W'(1 << GAIN_FRAC);
	localparam logic [SQUELCH_W-1:0] SQUELCH_RST  = '0;

	typedef enum logic [1:0] {
		MODE_ABS  = 2'd0,
		MODE_POS  = 2'd1,
		MODE_NEG  = 2'd2,
		MODE_BOTH = 2'd3
	} phase_mode_t;

	typedef enum logic [1:0] {
		SIGN_NONE = 2'd0,
		SIGN_POS  = 2'd1,
		SIGN_NEG  = 2'd2
	} sign_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SQUELCH = 2'd0,
		REG_GAIN    = 2'd1,
		REG_PHASE   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [SQUELCH_W-1:0] squelch;
		logic [GAIN_W-1:0]    gain;
		phase_mode_t          mode;
	} cfg_t;

	// Beat after squelch and phase selection
	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic             neg;
		logic             last;
	} mag_beat_t;

	// Beat after gain and saturation
	typedef struct packed {
		logic [PEAK_W-1:0] mag;
		sign_t             sign;
		logic              last;
	} lvl_beat_t;

endpackage

### rtl/wcpe_magnitude.sv
module wcpe_magnitude (
	input  logic                           clk,
	input  logic                           arst_n,
	input  wcpe_pkg::cfg_t                 cfg,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [wcpe_pkg::SAMPLE_BITS-1:0] in_sample,
	input  logic                           in_last,
	output logic                           out_valid,
	input  logic                           out_ready,
	output wcpe_pkg::mag_beat_t            out_beat
);
	import wcpe_pkg::*;

	logic             neg;
	logic [MAG_W-1:0] abs_mag;
	logic [CMP_W-1:0] abs_ext;
	logic [CMP_W-1:0] sq_ext;
	logic [CMP_W-1:0] diff;
	logic [MAG_W-1:0] sq_mag;
	mag_beat_t        beat_d;
	logic             valid_s2;
	mag_beat_t        beat_s2;

	// Magnitude; the most negative sample reads as 2^(SAMPLE_BITS-1)
	assign neg     = in_sample[SAMPLE_BITS-1];
	assign abs_mag = neg ? (~in_sample + 1'b1) : in_sample;

	// Squelch subtract, floored at zero
	assign abs_ext = CMP_W'(abs_mag);
	assign sq_ext  = CMP_W'(cfg.squelch);
	assign diff    = abs_ext - sq_ext;
	assign sq_mag  = (abs_ext < sq_ext) ? '0 : diff[MAG_W-1:0];

	// Phase mode: drop or fold signs before the gain
	always_comb begin
		beat_d.last = in_last;
		beat_d.mag  = sq_mag;
		beat_d.neg  = neg;
		unique case (cfg.mode)
			MODE_ABS: begin
				beat_d.neg = 1'b0;
			end
			MODE_POS: begin
				if (neg) beat_d.mag = '0;
			end
			MODE_NEG: begin
				if (!neg) beat_d.mag = '0;
				beat_d.neg = 1'b0;
			end
			default: begin
				beat_d.neg = neg;
			end
		endcase
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s2 <= beat_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_beat  = beat_s2;

endmodule

### rtl/wcpe_gain.sv
module wcpe_gain (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [wcpe_pkg::GAIN_W-1:0] gain,
	input  logic                in_valid,
	output logic                in_ready,
	input  wcpe_pkg::mag_beat_t in_beat,
	output logic                out_valid,
	input  logic                out_ready,
	output wcpe_pkg::lvl_beat_t out_beat
);
	import wcpe_pkg::*;

	logic [PROD_W-1:0]           prod;
	logic [PROD_W-GAIN_FRAC-1:0] scaled;
	logic                        sat;
	lvl_beat_t                   beat_d;
	logic                        valid_s3;
	lvl_beat_t                   beat_s3;

	// Q8.8 gain, truncated, then saturated to the peak width
	assign prod   = PROD_W'(in_beat.mag) * PROD_W'(gain);
	assign scaled = prod[PROD_W-1:GAIN_FRAC];
	assign sat    = |scaled[PROD_W-GAIN_FRAC-1:PEAK_W];

	always_comb begin
		beat_d.last = in_beat.last;
		beat_d.mag  = sat ? '1 : scaled[PEAK_W-1:0];
		if (beat_d.mag == '0) begin
			beat_d.sign = SIGN_NONE;
		end else if (in_beat.neg) begin
			beat_d.sign = SIGN_NEG;
		end else begin
			beat_d.sign = SIGN_POS;
		end
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s3 <= beat_d;
		end
	end

	assign out_valid = valid_s3;
	assign out_beat  = beat_s3;

endmodule

### rtl/wcpe_peak.sv
module wcpe_peak (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  wcpe_pkg::lvl_beat_t in_beat,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [wcpe_pkg::SAMPLE_BITS-1:0] m_tdata
);
	import wcpe_pkg::*;

	logic                   out_free;
	logic                   take;
	logic [PEAK_W-1:0]      peak_q;
	sign_t                  sign_q;
	logic [PEAK_W-1:0]      peak_nx;
	sign_t                  sign_nx;
	logic [SAMPLE_BITS-1:0] level;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] level_q;

	// A column end needs a free output register; other beats always pass
	assign out_free = !out_valid_q || m_tready;
	assign in_ready = !in_beat.last || out_free;
	assign take     = in_valid && in_ready;

	// Running peak and first nonzero sign, including this beat
	assign peak_nx = (in_beat.mag > peak_q) ? in_beat.mag : peak_q;
	assign sign_nx = (sign_q == SIGN_NONE) ? in_beat.sign : sign_q;

	always_comb begin
		unique case (sign_nx)
			SIGN_NONE: level = '0;
			SIGN_NEG:  level = ~{1'b0, peak_nx} + 1'b1;
			default:   level = {1'b0, peak_nx};
		endcase
	end

	// Column state, cleared on column end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
			sign_q <= SIGN_NONE;
		end else if (take) begin
			if (in_beat.last) begin
				peak_q <= '0;
				sign_q <= SIGN_NONE;
			end else begin
				peak_q <= peak_nx;
				sign_q <= sign_nx;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && in_beat.last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_beat.last) begin
			level_q <= level;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = level_q;

	// A peak is held exactly when a sign has been seen
	a_peak_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(peak_q != '0) == (sign_q != SIGN_NONE))
		else $error("peak and first sign disagree");

	// Column end clears the column state
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(take && in_beat.last) |=> (peak_q == '0 && sign_q == SIGN_NONE))
		else $error("column state not cleared");

	// Within a column the peak never falls
	a_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !in_beat.last) |=> (peak_q >= $past(peak_q)))
		else $error("running peak decreased");

	// Level is symmetric: the most negative code never appears
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (level_q != {1'b1, {PEAK_W{1'b0}}}))
		else $error("column level out of range");

endmodule

### rtl/waveform_column_peak_envelope.sv
// Peak-envelope decimation of one audio channel into display columns. Each
// sample beat on s_* (tdata = signed sample, tlast = last sample of a column)
// has the squelch level subtracted from its magnitude (floored at zero), is
// filtered by the phase mode, then scaled by the unsigned Q8.8 gain and
// saturated. The block tracks the column peak and the sign of the first sample
// that survives conditioning; on the tlast sample it sends one beat on m_*
// holding that peak with that sign (0 if nothing survived). Samples are taken
// one per cycle while s_tready is high; the tlast sample passes the input
// register, the squelch stage register and the gain multiplier stage register
// before the result register raises m_tvalid. s_tready drops only when a column
// end reaches the accumulator while the previous result is still not taken.
// Write the registers over cfg_* only while no sample is in flight.
module waveform_column_peak_envelope (
	input  logic                                clk,
	input  logic                                arst_n,
	// Sample stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [wcpe_pkg::SAMPLE_BITS-1:0]    s_tdata,  // [15:0] audio_sample
	input  logic                                s_tlast,  // column_end
	// Column level stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [wcpe_pkg::SAMPLE_BITS-1:0]    m_tdata,  // [15:0] column_level
	// Register writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wcpe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wcpe_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import wcpe_pkg::*;

	cfg_t                   cfg_q;
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   last_s1;
	logic                   mag_in_ready;
	logic                   mag_valid;
	logic                   gain_in_ready;
	mag_beat_t              mag_beat;
	logic                   gain_valid;
	logic                   peak_in_ready;
	lvl_beat_t              lvl_beat;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.squelch <= SQUELCH_RST;
			cfg_q.gain    <= GAIN_UNITY;
			cfg_q.mode    <= MODE_BOTH;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SQUELCH: cfg_q.squelch <= cfg_data[SQUELCH_W-1:0];
				REG_GAIN:    cfg_q.gain    <= cfg_data[GAIN_W-1:0];
				REG_PHASE:   cfg_q.mode    <= phase_mode_t'(cfg_data[1:0]);
				default: begin
				end
			endcase
		end
	end

	// Input register
	assign s_tready = !valid_s1 || mag_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1 <= s_tdata;
			last_s1   <= s_tlast;
		end
	end

	wcpe_magnitude u_magnitude (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (valid_s1),
		.in_ready  (mag_in_ready),
		.in_sample (sample_s1),
		.in_last   (last_s1),
		.out_valid (mag_valid),
		.out_ready (gain_in_ready),
		.out_beat  (mag_beat)
	);

	wcpe_gain u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.gain      (cfg_q.gain),
		.in_valid  (mag_valid),
		.in_ready  (gain_in_ready),
		.in_beat   (mag_beat),
		.out_valid (gain_valid),
		.out_ready (peak_in_ready),
		.out_beat  (lvl_beat)
	);

	wcpe_peak u_peak (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (gain_valid),
		.in_ready (peak_in_ready),
		.in_beat  (lvl_beat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import wcpe_pkg::*;

	localparam int IDLE_LIMIT = 4000;  // cycles with no beat on any channel
	localparam int DRAIN_WAIT = 12;    // extra wait after the last expected level arrives
	localparam int PHASES     = 13;
	localparam int PHASE_ITEMS = 148;

	// Expected column levels, predicted from each accepted sample beat
	class peak_envelope_scoreboard;
		logic [SQUELCH_W-1:0] squelch;
		logic [GAIN_W-1:0]    gain;
		phase_mode_t          mode;
		logic [PEAK_W-1:0]    peak;
		sign_t                first_sign;
		logic [SAMPLE_BITS-1:0] expected_levels[$];
		int errors;
		int samples;
		int levels;

		function new();
			squelch    = SQUELCH_RST;
			gain       = GAIN_UNITY;
			mode       = MODE_BOTH;
			peak       = '0;
			first_sign = SIGN_NONE;
			errors     = 0;
			samples    = 0;
			levels     = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SQUELCH: squelch = data[SQUELCH_W-1:0];
				REG_GAIN:    gain = data[GAIN_W-1:0];
				REG_PHASE:   mode = phase_mode_t'(data[1:0]);
				default:     ;
			endcase
		endfunction

		// Squelch, gain with saturation, then phase filtering
		function logic [PEAK_W-1:0] condition_sample(logic [SAMPLE_BITS-1:0] raw,
				output sign_t sg);
			logic [MAG_W:0]    mag;
			logic [PROD_W:0]   prod;
			logic [PEAK_W-1:0] sat;
			mag = raw[SAMPLE_BITS-1] ? ((MAG_W+1)'(1) << MAG_W) - {1'b0, raw} : {1'b0, raw};
			if (raw == '0)
				sg = SIGN_NONE;
			else if (raw[SAMPLE_BITS-1])
				sg = SIGN_NEG;
			else
				sg = SIGN_POS;
			mag = (mag < squelch) ? '0 : mag - squelch;
			prod = ((PROD_W+1)'(mag) * gain) >> GAIN_FRAC;
			sat = (prod > {PEAK_W{1'b1}}) ? {PEAK_W{1'b1}} : prod[PEAK_W-1:0];
			case (mode)
				MODE_ABS: sg = SIGN_POS;
				MODE_POS: if (sg == SIGN_NEG) sat = '0;
				MODE_NEG: begin
					if (sg == SIGN_POS)
						sat = '0;
					else
						sg = SIGN_POS;
				end
				default: ;
			endcase
			if (sat == '0)
				sg = SIGN_NONE;
			return sat;
		endfunction

		function void note_sample(logic [SAMPLE_BITS-1:0] raw, logic last);
			sign_t sg;
			logic [PEAK_W-1:0] mag;
			logic [SAMPLE_BITS-1:0] level;
			samples++;
			mag = condition_sample(raw, sg);
			if (first_sign == SIGN_NONE && sg != SIGN_NONE)
				first_sign = sg;
			if (mag > peak)
				peak = mag;
			if (last) begin
				if (first_sign == SIGN_NONE)
					level = '0;
				else if (first_sign == SIGN_NEG)
					level = -{1'b0, peak};
				else
					level = {1'b0, peak};
				expected_levels.push_back(level);
				peak = '0;
				first_sign = SIGN_NONE;
			end
		endfunction

		function void check_level(logic [SAMPLE_BITS-1:0] got);
			logic [SAMPLE_BITS-1:0] want;
			levels++;
			if (expected_levels.size() == 0) begin
				$error("column_level: unexpected beat, actual %0d", $signed(got));
				errors++;
			end else begin
				want = expected_levels.pop_front();
				if (want !== got) begin
					$error("column_level: expected %0d, actual %0d",
						$signed(want), $signed(got));
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_levels.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [SAMPLE_BITS-1:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [SAMPLE_BITS-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	peak_envelope_scoreboard board = new();
	bit quiet = 1'b0;   // no idling on either side while set
	int settings = 1;   // reset setting counts as the first
	int idle_cycles = 0;

	waveform_column_peak_envelope uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Sample beat: optional gap, then hold until accepted
	task automatic send_sample(logic [SAMPLE_BITS-1:0] data, logic last);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		board.note_sample(data, last);
		if ($urandom_range(0, 39) == 0)
			quiet = !quiet;
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Let every expected level arrive and the pipe empty out
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.pending() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		logic [SAMPLE_BITS-1:0] v;
		case ($urandom_range(0, 11))
			0: v = 16'h8000;
			1: v = 16'h7FFF;
			2: v = '0;
			3: v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0001;
			4, 5: begin
				v = SAMPLE_BITS'($urandom_range(0, 700));
				if ($urandom_range(0, 1))
					v = -v;
			end
			default: v = SAMPLE_BITS'($urandom);
		endcase
		return v;
	endfunction

	// Result side: random stall before each beat
	initial begin
		int stall;
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 3);
			repeat (stall) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			board.check_level(m_tdata);
	end

	// Watchdog on channel activity
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("waveform_column_peak_envelope verification failed");
			$finish;
		end
	end

	initial begin
		int left;
		logic [SQUELCH_W-1:0] sq;
		logic [GAIN_W-1:0] gn;
		phase_mode_t md;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed columns at the reset setting
		send_sample(16'h0000, 1'b0);   // all-zero column gives level 0
		send_sample(16'h0000, 1'b1);
		send_sample(16'h7FFF, 1'b1);   // positive full scale
		send_sample(16'h8000, 1'b1);   // most negative saturates to -32767
		send_sample(16'hFFFF, 1'b0);   // first sign negative, larger positive later
		send_sample(16'h0005, 1'b0);
		send_sample(16'hFFFD, 1'b1);
		send_sample(16'h0000, 1'b0);   // zero carries no sign
		send_sample(16'h0064, 1'b0);
		send_sample(16'hFF38, 1'b1);
		drain();

		// Phase mode filtering on one mixed column each
		for (int m = 0; m < 4; m++) begin
			write_reg(REG_PHASE, CFG_DATA_W'(m));
			settings++;
			send_sample(16'hF000, 1'b0);
			send_sample(16'h0800, 1'b1);
			drain();
		end

		// Random phases; the first ones sit at the register extremes
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin sq = '0; gn = '1; md = MODE_ABS; end
				1: begin sq = '1; gn = GAIN_UNITY; md = MODE_POS; end
				2: begin sq = '0; gn = '0; md = MODE_NEG; end
				3: begin
					sq = SQUELCH_W'($urandom_range(0, 400));
					gn = '1;
					md = MODE_BOTH;
				end
				default: begin
					case ($urandom_range(0, 3))
						0: sq = '0;
						1: sq = SQUELCH_W'($urandom_range(0, 1023));
						2: sq = '1;
						default: sq = SQUELCH_W'($urandom);
					endcase
					case ($urandom_range(0, 3))
						0: gn = GAIN_UNITY;
						1: gn = GAIN_W'($urandom_range(0, 512));
						2: gn = '1;
						default: gn = GAIN_W'($urandom);
					endcase
					md = phase_mode_t'($urandom_range(0, 3));
				end
			endcase
			write_reg(REG_SQUELCH, {1'b0, sq});
			write_reg(REG_GAIN, gn);
			write_reg(REG_PHASE, CFG_DATA_W'(md));
			settings++;

			left = 0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (left == 0)
					left = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
						: $urandom_range(1, 8);
				left--;
				send_sample(pick_sample(), left == 0);
			end
			drain();
		end

		$display("Covered %0d sample beats and %0d column levels across %0d register settings",
			board.samples, board.levels, settings);
		if (board.errors == 0 && board.pending() == 0)
			$display("waveform_column_peak_envelope verification clean");
		else
			$display("waveform_column_peak_envelope verification failed");
		$finish;
	end

endmodule

### files.f
rtl/wcpe_pkg.sv
rtl/wcpe_magnitude.sv
rtl/wcpe_gain.sv
rtl/wcpe_peak.sv
rtl/waveform_column_peak_envelope.sv
test/tb_top.sv
